/* rtl/core/pfwa_pkg.sv */
// Shared types and constants of the pressure frame window alarm.
// Holds packet codes, register indexes and the controller/datapath link.
// Depends on nothing.
package pfwa_pkg;

   localparam int DATA_W    = 17;
   localparam int BYTE_W    = 8;
   localparam int TARE_W    = 16;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int POS_W     = 4;

   localparam logic [FUNC_W-1:0] FUNC_BYTE      = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LINK_LOST = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ACK       = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ARMED     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [BYTE_W-1:0] HDR0_BYTE    = 8'hA5;
   localparam logic [BYTE_W-1:0] HDR1_BYTE    = 8'h5A;
   localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h99;

   localparam logic [POS_W-1:0] POS_HDR0    = 4'd0;
   localparam logic [POS_W-1:0] POS_HDR1    = 4'd1;
   localparam logic [POS_W-1:0] POS_PHIGH   = 4'd5;
   localparam logic [POS_W-1:0] POS_PLOW    = 4'd6;
   localparam logic [POS_W-1:0] POS_TRAILER = 4'd9;
   localparam logic [POS_W-1:0] FRAME_MIN   = 4'd10;

   localparam logic [DATA_W-1:0] THRESHOLD_RESET = 17'd1000;

   typedef struct packed {
      logic accept;
      logic ram_rd;
      logic win_update;
      logic div_start;
      logic check;
      logic load_out;
   } pfwa_cmd_type;

   typedef struct packed {
      logic item_end;
      logic item_ok;
      logic div_done;
      logic out_free;
   } pfwa_sts_type;

endpackage

/* rtl/core/pfwa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the sample window; depends on nothing.
module pfwa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/pfwa_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Computes the window mean magnitude; depends on nothing.
module pfwa_div #(
   parameter int DVD_W = 22,
   parameter int DVS_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (dvs_ff != '0))
      else $error("divide by zero fill count");
`endif

endmodule

/* rtl/core/pfwa_dp.sv */
// Datapath: packet parser, configuration registers, sample window, divider
// and output register. Depends on pfwa_pkg, pfwa_ram and pfwa_div.
module pfwa_dp #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pfwa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfwa_pkg::DATA_W-1:0]       csr_data,
   input  logic [pfwa_pkg::FUNC_W-1:0]       req_func,
   input  logic [pfwa_pkg::BYTE_W-1:0]       req_rx_byte,
   input  logic                              req_end_of_packet,
   input  logic                              req_hold_off,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_frame_ok,
   output logic signed [pfwa_pkg::DATA_W-1:0] rsp_tared_pressure,
   output logic signed [pfwa_pkg::DATA_W-1:0] rsp_window_mean,
   output logic                              rsp_alarm_raised,
   output logic                              rsp_alarm_active,
   input  pfwa_pkg::pfwa_cmd_type            cmd,
   output pfwa_pkg::pfwa_sts_type            sts
);

   import pfwa_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = DATA_W + CNT_W;

   // configuration
   logic              armed_ff, armed_in;
   logic [TARE_W-1:0] tare_ff, tare_in;
   logic [DATA_W-1:0] thresh_ff, thresh_in;

   // parser
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              hdr_ok_ff, hdr_ok_in;
   logic              trl_ok_ff, trl_ok_in;
   logic [BYTE_W-1:0] phigh_ff, phigh_in;
   logic [BYTE_W-1:0] plow_ff, plow_in;

   // current packet
   logic                     ok_ff, ok_in;
   logic                     hold_ff, hold_in;
   logic signed [DATA_W-1:0] tared_ff, tared_in;
   logic signed [DATA_W-1:0] mean_ff, mean_in;
   logic                     raised_ff, raised_in;

   // window
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    latched_ff, latched_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic signed [DATA_W-1:0] rsp_tared_ff, rsp_tared_in;
   logic signed [DATA_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic                     rsp_raised_ff, rsp_raised_in;
   logic                     rsp_active_ff, rsp_active_in;

   // combinational helpers
   logic [POS_W-1:0]         pos_next;
   logic                     hdr_next;
   logic                     trl_next;
   logic [BYTE_W-1:0]        phigh_next;
   logic [BYTE_W-1:0]        plow_next;
   logic                     ok_next;
   logic signed [DATA_W-1:0] tared_calc;
   logic                     full;
   logic [DATA_W-1:0]        rd_data;
   logic signed [SUM_W-1:0]  old_ext;
   logic signed [SUM_W-1:0]  new_ext;
   logic [SUM_W-1:0]         sum_mag;
   logic                     div_done;
   logic [SUM_W-1:0]         quotient;
   logic [DATA_W-1:0]        q_trunc;
   logic signed [DATA_W:0]   dev;
   logic [DATA_W:0]          dev_mag;
   logic                     raise;
   logic                     is_byte;

   pfwa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.win_update),
      .wr_addr (idx_ff),
      .wr_data (tared_ff),
      .rd_en   (cmd.ram_rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   pfwa_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_mag),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // parse the offered byte
   always_comb begin
      hdr_next   = hdr_ok_ff;
      trl_next   = trl_ok_ff;
      phigh_next = phigh_ff;
      plow_next  = plow_ff;
      case (pos_ff)
         POS_HDR0: begin
            if (req_rx_byte != HDR0_BYTE) hdr_next = 1'b0;
         end
         POS_HDR1: begin
            if (req_rx_byte != HDR1_BYTE) hdr_next = 1'b0;
         end
         POS_PHIGH: phigh_next = req_rx_byte;
         POS_PLOW:  plow_next  = req_rx_byte;
         POS_TRAILER: trl_next = (req_rx_byte == TRAILER_BYTE);
         default: ;
      endcase
      pos_next   = (pos_ff < FRAME_MIN) ? pos_ff + 1'b1 : pos_ff;
      ok_next    = (pos_next >= FRAME_MIN) && hdr_next && trl_next;
      tared_calc = $signed({1'b0, phigh_next, plow_next}) - $signed({1'b0, tare_ff});
   end

   always_comb begin
      is_byte = (req_func == FUNC_BYTE);
      full    = (cnt_ff == CNT_W'(WINDOW_DEPTH));
      old_ext = full ? $signed({{(SUM_W-DATA_W){rd_data[DATA_W-1]}}, rd_data})
                     : '0;
      new_ext = $signed({{(SUM_W-DATA_W){tared_ff[DATA_W-1]}}, tared_ff});
      sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      q_trunc = quotient[DATA_W-1:0];
      dev     = $signed({tared_ff[DATA_W-1], tared_ff})
              - $signed({mean_ff[DATA_W-1], mean_ff});
      dev_mag = dev[DATA_W] ? (DATA_W+1)'(-dev) : (DATA_W+1)'(dev);
      raise   = armed_ff && !latched_ff && !hold_ff && full
              && (dev_mag > {1'b0, thresh_ff});
   end

   always_comb begin
      armed_in      = armed_ff;
      tare_in       = tare_ff;
      thresh_in     = thresh_ff;
      pos_in        = pos_ff;
      hdr_ok_in     = hdr_ok_ff;
      trl_ok_in     = trl_ok_ff;
      phigh_in      = phigh_ff;
      plow_in       = plow_ff;
      ok_in         = ok_ff;
      hold_in       = hold_ff;
      tared_in      = tared_ff;
      mean_in       = mean_ff;
      raised_in     = raised_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      latched_in    = latched_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ok_in     = rsp_ok_ff;
      rsp_tared_in  = rsp_tared_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_raised_in = rsp_raised_ff;
      rsp_active_in = rsp_active_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_ARMED:     armed_in  = csr_data[0];
            CSR_TARE:      tare_in   = csr_data[TARE_W-1:0];
            CSR_THRESHOLD: thresh_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         case (req_func)
            FUNC_BYTE: begin
               phigh_in = phigh_next;
               plow_in  = plow_next;
               if (req_end_of_packet) begin
                  // latch the packet, then restart the parser
                  ok_in     = ok_next;
                  hold_in   = req_hold_off;
                  tared_in  = tared_calc;
                  raised_in = 1'b0;
                  pos_in    = '0;
                  hdr_ok_in = 1'b1;
                  trl_ok_in = 1'b0;
               end else begin
                  pos_in    = pos_next;
                  hdr_ok_in = hdr_next;
                  trl_ok_in = trl_next;
               end
            end
            FUNC_LINK_LOST: begin
               pos_in    = '0;
               hdr_ok_in = 1'b1;
               trl_ok_in = 1'b0;
               idx_in    = '0;
               cnt_in    = '0;
               sum_in    = '0;
            end
            FUNC_ACK: latched_in = 1'b0;
            default: ;
         endcase
      end

      if (cmd.win_update) begin
         // drop the oldest sample once full, add the new one
         sum_in = sum_ff - old_ext + new_ext;
         idx_in = (idx_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
         if (!full) cnt_in = cnt_ff + 1'b1;
      end

      if (div_done) begin
         mean_in = sum_ff[SUM_W-1] ? $signed(-q_trunc) : $signed(q_trunc);
      end

      if (cmd.check) begin
         raised_in  = raise;
         latched_in = latched_ff || raise;
      end

      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = ok_ff;
         rsp_tared_in  = ok_ff ? tared_ff : '0;
         rsp_mean_in   = ok_ff ? mean_ff : '0;
         rsp_raised_in = raised_ff;
         rsp_active_in = latched_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         tare_ff      <= '0;
         thresh_ff    <= THRESHOLD_RESET;
         pos_ff       <= '0;
         hdr_ok_ff    <= 1'b1;
         trl_ok_ff    <= 1'b0;
         raised_ff    <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         latched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         armed_ff     <= armed_in;
         tare_ff      <= tare_in;
         thresh_ff    <= thresh_in;
         pos_ff       <= pos_in;
         hdr_ok_ff    <= hdr_ok_in;
         trl_ok_ff    <= trl_ok_in;
         raised_ff    <= raised_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         latched_ff   <= latched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phigh_ff      <= phigh_in;
      plow_ff       <= plow_in;
      ok_ff         <= ok_in;
      hold_ff       <= hold_in;
      tared_ff      <= tared_in;
      mean_ff       <= mean_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_tared_ff  <= rsp_tared_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_raised_ff <= rsp_raised_in;
      rsp_active_ff <= rsp_active_in;
   end

   always_comb begin
      sts.item_end = is_byte && req_end_of_packet;
      sts.item_ok  = ok_next;
      sts.div_done = div_done;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_ok       = rsp_ok_ff;
   assign rsp_tared_pressure = rsp_tared_ff;
   assign rsp_window_mean    = rsp_mean_ff;
   assign rsp_alarm_raised   = rsp_raised_ff;
   assign rsp_alarm_active   = rsp_active_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("window fill count overflow");
   a_idx_tracks_cnt: assert property (@(posedge clock) disable iff (reset)
      !full |-> (CNT_W'(idx_ff) == cnt_ff))
      else $error("write index out of step with fill count");
   a_raised_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_raised_ff) |-> rsp_active_ff)
      else $error("alarm raised but not active");
`endif

endmodule

/* rtl/core/pfwa_ctrl.sv */
// Controller state machine: sequences accept, window update, division,
// alarm check and result load. Depends on pfwa_pkg.
module pfwa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pfwa_pkg::pfwa_sts_type sts,
   output pfwa_pkg::pfwa_cmd_type cmd
);

   import pfwa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SUM,
      S_START,
      S_DIV,
      S_CHECK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff, req_stall_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && sts.item_end) begin
               state_in = sts.item_ok ? S_READ : S_DONE;
            end
         end
         S_READ: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.win_update = 1'b1;
            state_in       = S_START;
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the request
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      req_stall_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

`ifndef SYNTHESIS
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !sts.out_free) |=> (state_ff == S_DONE))
      else $error("result dropped while output busy");
`endif

endmodule

/* rtl/core/pressure_frame_window_alarm.sv */
// Pressure frame window alarm: parses sensor packets a byte per request,
// averages tared readings over a sliding window and latches a deviation alarm.
// Request channel (req_*): one item per request; func selects packet byte,
//   link lost (empties window, drops partial packet) or alarm acknowledge.
// Response channel (rsp_*): one response per packet end byte, carrying the
//   frame check, tared reading, window mean and alarm flags.
// Config channel (csr_*): index 0 armed, 1 tare offset, 2 alarm threshold;
//   always ready, write only while the block is idle.
// Sequencing: a non-final packet byte, link lost or acknowledge is taken
//   in the idle state. A packet end with a bad frame goes straight to the
//   response register load; a good frame passes window RAM read, sum update,
//   divider start, then the divider at one quotient bit per cycle for a
//   22-bit quotient at the default depth, and the alarm compare.
// req_stall is high while a packet end is in progress.
// Reset is synchronous: window empty, parser restarted, alarm clear,
//   registers at their defaults. A stalled response holds in the output
//   register; the next packet end waits for it, other requests go on.
// Depends on pfwa_pkg, pfwa_ctrl and pfwa_dp.
module pressure_frame_window_alarm #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfwa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfwa_pkg::DATA_W-1:0]         csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pfwa_pkg::FUNC_W-1:0]         req_func,
   input  logic [pfwa_pkg::BYTE_W-1:0]         req_rx_byte,
   input  logic                                req_end_of_packet,
   input  logic                                req_hold_off,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_frame_ok,
   output logic signed [pfwa_pkg::DATA_W-1:0]  rsp_tared_pressure,
   output logic signed [pfwa_pkg::DATA_W-1:0]  rsp_window_mean,
   output logic                                rsp_alarm_raised,
   output logic                                rsp_alarm_active
);

   import pfwa_pkg::*;

   pfwa_cmd_type cmd;
   pfwa_sts_type sts;

   pfwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfwa_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_func           (req_func),
      .req_rx_byte        (req_rx_byte),
      .req_end_of_packet  (req_end_of_packet),
      .req_hold_off       (req_hold_off),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_tared_pressure (rsp_tared_pressure),
      .rsp_window_mean    (rsp_window_mean),
      .rsp_alarm_raised   (rsp_alarm_raised),
      .rsp_alarm_active   (rsp_alarm_active),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule
